### rtl/core/lpme_pkg.sv
// Package with the constants, types and request codes of the lattice polymer move engine.
package lpme_pkg;

   localparam int ChainLenDefault = 64;
   localparam int CoordWidth = 7;
   localparam int IndexWidth = 6;
   localparam int E2eWidth = 12;
   localparam int GyrWidth = 21;

   typedef enum logic [1:0] {
      REQ_REPTATE = 2'd0,
      REQ_PIVOT   = 2'd1,
      REQ_READ    = 2'd2,
      REQ_RSVD    = 2'd3
   } req_code_type;

   typedef enum logic [1:0] {
      DIR_MINUS_X = 2'd0,
      DIR_PLUS_X  = 2'd1,
      DIR_MINUS_Y = 2'd2,
      DIR_PLUS_Y  = 2'd3
   } dir_code_type;

   typedef enum logic [1:0] {
      SYM_ROT_CCW  = 2'd0,
      SYM_ROT_CW   = 2'd1,
      SYM_MIRROR_Y = 2'd2,
      SYM_MIRROR_X = 2'd3
   } sym_code_type;

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_CHECK  = 5'b00010,
      ST_UPDATE = 5'b00100,
      ST_STATS  = 5'b01000,
      ST_REPLY  = 5'b10000
   } state_type;

   // Controls sent from the sequencer to every cell of the chain.
   typedef struct packed {
      logic shift_down;
      logic shift_up;
      logic load_head;
      logic commit_seg;
      logic translate;
      logic rotate;
   } cell_ctrl_type;

endpackage

### rtl/core/lpme_cell.sv
// One chain cell holding a monomer position; it loads the pivot image on commit.
module lpme_cell
   import lpme_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  cell_ctrl_type         ctrl,
   input  logic [CoordWidth-1:0] init_x,
   input  logic [CoordWidth-1:0] init_y,
   input  logic [CoordWidth-1:0] head_x,
   input  logic [CoordWidth-1:0] head_y,
   input  logic                  is_head,
   input  logic                  in_segment,
   input  logic [CoordWidth-1:0] seg_x,
   input  logic [CoordWidth-1:0] seg_y,
   input  logic [CoordWidth-1:0] shift_x,
   input  logic [CoordWidth-1:0] shift_y,
   input  logic [CoordWidth-1:0] lo_x,
   input  logic [CoordWidth-1:0] lo_y,
   input  logic [CoordWidth-1:0] hi_x,
   input  logic [CoordWidth-1:0] hi_y,
   output logic [CoordWidth-1:0] pos_x,
   output logic [CoordWidth-1:0] pos_y
);

   logic [CoordWidth-1:0] x_ff, x_in, y_ff, y_in;

   always_comb begin
      x_in = x_ff;
      y_in = y_ff;
      if (ctrl.load_head && is_head) begin
         x_in = head_x;
         y_in = head_y;
      end else if (ctrl.shift_down) begin
         x_in = lo_x;
         y_in = lo_y;
      end else if (ctrl.shift_up) begin
         x_in = hi_x;
         y_in = hi_y;
      end else if (ctrl.rotate) begin
         x_in = hi_x;
         y_in = hi_y;
      end else if (ctrl.commit_seg && in_segment) begin
         x_in = seg_x;
         y_in = seg_y;
      end else if (ctrl.translate) begin
         x_in = x_ff + shift_x;
         y_in = y_ff + shift_y;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_ff <= init_x;
         y_ff <= init_y;
      end else begin
         x_ff <= x_in;
         y_ff <= y_in;
      end
   end

   assign pos_x = x_ff;
   assign pos_y = y_ff;

endmodule

### rtl/core/lattice_polymer_move_engine.sv
// Top level of the lattice polymer move engine: cell chain and sequencer.
//
//   channel | ports                                        | direction
//   request | start, req_* (in), busy (out)                | in
//   result  | rsp_valid, rsp_*                             | out
//
// Busy goes high at the edge that accepts a request and stays high through the reply state.
// The result strobe follows in the next cycle with busy already low, so a new request
// can be accepted as soon as the strobe appears.
// The chain rotates one cell a cycle past cell 0, where the checks and sums are made; the
// overlap scan takes one setup step and one full turn, the statistics another.
// Reset loads the centred horizontal chain.
// The result strobe rsp_valid lasts one cycle and cannot be stalled.
module lattice_polymer_move_engine
   import lpme_pkg::*;
#(
   parameter int CHAIN_LEN = ChainLenDefault
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [1:0]            req_type,
   input  logic                  req_chain_end,
   input  logic [1:0]            req_direction,
   input  logic [IndexWidth-1:0] req_monomer_index,
   input  logic [1:0]            req_symmetry_op,
   output logic                  rsp_valid,
   output logic                  rsp_accepted,
   output logic [E2eWidth-1:0]   rsp_end_to_end_sq,
   output logic [GyrWidth-1:0]   rsp_gyration_scaled,
   output logic [CoordWidth-1:0] rsp_monomer_x,
   output logic [CoordWidth-1:0] rsp_monomer_y
);

   localparam int BoxMid = (CHAIN_LEN + 3) / 2;
   localparam int MidIdx = CHAIN_LEN / 2;
   localparam int CntW = $clog2(CHAIN_LEN + 1);

   logic [CoordWidth-1:0] px [CHAIN_LEN];
   logic [CoordWidth-1:0] py [CHAIN_LEN];
   logic [CoordWidth-1:0] seg_xv [CHAIN_LEN];
   logic [CoordWidth-1:0] seg_yv [CHAIN_LEN];
   logic [CHAIN_LEN-1:0]  in_seg;
   cell_ctrl_type ctrl;

   state_type state_ff, state_in;
   logic [CntW-1:0] cnt_ff, cnt_in;
   req_code_type req_ff;
   logic end_ff;
   logic [1:0] dir_ff, op_ff;
   logic [IndexWidth-1:0] idx_ff;
   logic ok_ff, ok_in;
   logic [CoordWidth-1:0] hx_ff, hy_ff, pvx_ff, pvy_ff;
   logic [CoordWidth-1:0] shx, shy;
   logic signed [CoordWidth+CntW+1:0] sx_ff, sy_ff;
   logic [2*CoordWidth+CntW+1:0] sq_ff;
   logic [CoordWidth-1:0] mx_ff, my_ff;
   logic valid_ff;
   logic [E2eWidth-1:0] e2e_ff;
   logic [GyrWidth-1:0] gyr_ff;

   wire idx_ok = 32'(idx_ff) < 32'(CHAIN_LEN);
   wire pivot_ok = (req_ff == REQ_PIVOT) && idx_ok;

   assign shx = CoordWidth'(BoxMid) - px[MidIdx];
   assign shy = CoordWidth'(BoxMid) - py[MidIdx];

   // Each cell's pivot image, and whether it belongs to the moving segment.
   genvar g;
   generate
      for (g = 0; g < CHAIN_LEN; g++) begin : g_seg
         logic [CoordWidth-1:0] dx, dy;
         assign dx = px[g] - pvx_ff;
         assign dy = py[g] - pvy_ff;
         assign in_seg[g] = 32'(g) >= 32'(idx_ff);
         always_comb begin
            case (sym_code_type'(op_ff))
               SYM_ROT_CCW: begin
                  seg_xv[g] = pvx_ff - dy;
                  seg_yv[g] = pvy_ff + dx;
               end
               SYM_ROT_CW: begin
                  seg_xv[g] = pvx_ff + dy;
                  seg_yv[g] = pvy_ff - dx;
               end
               SYM_MIRROR_Y: begin
                  seg_xv[g] = pvx_ff + dx;
                  seg_yv[g] = pvy_ff - dy;
               end
               default: begin
                  seg_xv[g] = pvx_ff - dx;
                  seg_yv[g] = pvy_ff + dy;
               end
            endcase
         end
         lpme_cell u_cell (
            .clock(clock), .reset(reset), .ctrl(ctrl),
            .init_x(CoordWidth'(g - MidIdx + BoxMid)),
            .init_y(CoordWidth'(BoxMid)),
            .head_x(hx_ff), .head_y(hy_ff),
            .is_head(end_ff ? (g == CHAIN_LEN - 1) : (g == 0)),
            .in_segment(in_seg[g]),
            .seg_x(seg_xv[g]), .seg_y(seg_yv[g]),
            .shift_x(shx), .shift_y(shy),
            .lo_x(px[(g + CHAIN_LEN - 1) % CHAIN_LEN]),
            .lo_y(py[(g + CHAIN_LEN - 1) % CHAIN_LEN]),
            .hi_x(px[(g + 1) % CHAIN_LEN]),
            .hi_y(py[(g + 1) % CHAIN_LEN]),
            .pos_x(px[g]), .pos_y(py[g])
         );
      end
   endgenerate

   // During a scan the chain rotates so that the original monomer cnt-1 sits in cell 0;
   // its original index is cnt-1, and the matching pivot image is held in place.
   logic [CntW-1:0] orig_idx;
   assign orig_idx = cnt_ff - 1'b1;
   logic [CoordWidth-1:0] cx, cy;
   assign cx = px[0];
   assign cy = py[0];

   logic hit_rep, hit_piv;
   // Segment images are compared against the earlier monomers. The images are
   // held in img registers that stay in place while the chain turns.
   logic [CoordWidth-1:0] imgx_ff [CHAIN_LEN];
   logic [CoordWidth-1:0] imgy_ff [CHAIN_LEN];
   logic [CHAIN_LEN-1:0]  imgv_ff;
   logic [CHAIN_LEN-1:0]  hitv;

   assign hit_rep = (cx == hx_ff) && (cy == hy_ff) &&
                    (32'(orig_idx) != (end_ff ? 32'd0 : 32'(CHAIN_LEN - 1)));

   // Each image register compares itself against the earlier monomer passing cell 0.
   generate
      for (g = 0; g < CHAIN_LEN; g++) begin : g_img
         assign hitv[g] = imgv_ff[g] && (imgx_ff[g] == cx) && (imgy_ff[g] == cy);
      end
   endgenerate
   assign hit_piv = (|hitv) && (32'(orig_idx) < 32'(idx_ff));

   wire signed [CoordWidth+1:0] rx = $signed({2'b00, cx}) - (CoordWidth+2)'(BoxMid);
   wire signed [CoordWidth+1:0] ry = $signed({2'b00, cy}) - (CoordWidth+2)'(BoxMid);
   wire signed [2*CoordWidth+3:0] rx2 = rx * rx;
   wire signed [2*CoordWidth+3:0] ry2 = ry * ry;
   wire signed [2*(CoordWidth+CntW+2)-1:0] sx2 = sx_ff * sx_ff;
   wire signed [2*(CoordWidth+CntW+2)-1:0] sy2 = sy_ff * sy_ff;
   wire signed [CoordWidth:0] ex = $signed({1'b0, px[0]}) - $signed({1'b0, px[CHAIN_LEN-1]});
   wire signed [CoordWidth:0] ey = $signed({1'b0, py[0]}) - $signed({1'b0, py[CHAIN_LEN-1]});
   wire signed [2*CoordWidth+1:0] ex2 = ex * ex;
   wire signed [2*CoordWidth+1:0] ey2 = ey * ey;

   logic [CoordWidth-1:0] nhx, nhy;
   always_comb begin
      nhx = end_ff ? px[CHAIN_LEN-1] : px[0];
      nhy = end_ff ? py[CHAIN_LEN-1] : py[0];
      case (dir_code_type'(dir_ff))
         DIR_MINUS_X: nhx = nhx - 1'b1;
         DIR_PLUS_X:  nhx = nhx + 1'b1;
         DIR_MINUS_Y: nhy = nhy - 1'b1;
         default:     nhy = nhy + 1'b1;
      endcase
   end

   logic last;
   assign last = 32'(cnt_ff) == 32'(CHAIN_LEN);

   always_comb begin
      state_in = state_ff;
      cnt_in = cnt_ff;
      ok_in = ok_ff;
      ctrl = '0;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_CHECK;
               cnt_in = '0;
               ok_in = 1'b1;
            end
         end
         ST_CHECK: begin
            if (cnt_ff != '0) begin
               if (req_ff == REQ_REPTATE) begin
                  if (hit_rep) ok_in = 1'b0;
               end else if (req_ff == REQ_PIVOT) begin
                  if (!idx_ok || hit_piv) ok_in = 1'b0;
               end else begin
                  ok_in = 1'b0;
               end
               ctrl.rotate = 1'b1;
            end
            cnt_in = cnt_ff + 1'b1;
            if (last) state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (ok_ff) begin
               if (req_ff == REQ_REPTATE) begin
                  ctrl.shift_down = !end_ff;
                  ctrl.shift_up = end_ff;
                  ctrl.load_head = 1'b1;
               end else begin
                  ctrl.commit_seg = 1'b1;
               end
            end
            state_in = ST_STATS;
            cnt_in = '0;
         end
         ST_STATS: begin
            if (cnt_ff == '0) ctrl.translate = ok_ff;
            else ctrl.rotate = 1'b1;
            cnt_in = cnt_ff + 1'b1;
            if (last) state_in = ST_REPLY;
         end
         ST_REPLY: begin
            state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // In ST_STATS a count of 0 translates (or idles); counts 1..N rotate and sum cell 0.
   wire stats_sum = (state_ff == ST_STATS) && (cnt_ff != '0);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         cnt_ff <= '0;
         ok_ff <= 1'b0;
         valid_ff <= 1'b0;
         imgv_ff <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff <= cnt_in;
         ok_ff <= ok_in;
         valid_ff <= (state_ff == ST_REPLY);
         if (state_ff == ST_IDLE && start) imgv_ff <= '0;
         else if (state_ff == ST_CHECK && cnt_ff == '0) imgv_ff <= in_seg & {CHAIN_LEN{pivot_ok}};
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         req_ff <= req_code_type'(req_type);
         end_ff <= req_chain_end;
         dir_ff <= req_direction;
         op_ff <= req_symmetry_op;
         idx_ff <= req_monomer_index;
         pvx_ff <= px[req_monomer_index];
         pvy_ff <= py[req_monomer_index];
         mx_ff <= '0;
         my_ff <= '0;
         if (req_type == REQ_READ && 32'(req_monomer_index) < 32'(CHAIN_LEN)) begin
            mx_ff <= px[req_monomer_index];
            my_ff <= py[req_monomer_index];
         end
      end
      if (state_ff == ST_CHECK && cnt_ff == '0) begin
         hx_ff <= nhx;
         hy_ff <= nhy;
         for (int k = 0; k < CHAIN_LEN; k++) begin
            imgx_ff[k] <= seg_xv[k];
            imgy_ff[k] <= seg_yv[k];
         end
      end
      if (state_ff == ST_UPDATE) begin
         sx_ff <= '0;
         sy_ff <= '0;
         sq_ff <= '0;
      end
      if (stats_sum) begin
         sx_ff <= sx_ff + (CoordWidth+CntW+2)'(rx);
         sy_ff <= sy_ff + (CoordWidth+CntW+2)'(ry);
         sq_ff <= sq_ff + (2*CoordWidth+CntW+2)'(rx2) + (2*CoordWidth+CntW+2)'(ry2);
      end
      if (state_ff == ST_REPLY) begin
         e2e_ff <= E2eWidth'(ex2 + ey2);
         gyr_ff <= GyrWidth'(sq_ff * CHAIN_LEN) - GyrWidth'(sx2) - GyrWidth'(sy2);
      end
   end

   assign busy = (state_ff != ST_IDLE);
   assign rsp_valid = valid_ff;
   assign rsp_accepted = ok_ff;
   assign rsp_end_to_end_sq = e2e_ff;
   assign rsp_gyration_scaled = gyr_ff;
   assign rsp_monomer_x = mx_ff;
   assign rsp_monomer_y = my_ff;

endmodule

### tb/sv/tb.sv
// Self-checking testbench for the lattice polymer move engine with a built-in chain predictor.
`timescale 1ns / 100ps

module tb;
   import lpme_pkg::*;

   localparam int NMON = 64;
   localparam int BOX_CTR = (NMON + 3) / 2;
   localparam int MID_MON = NMON / 2;
   localparam int MOVE_CYCLES = 2 * NMON + 5;
   localparam int CYCLE_LIMIT = 2000000;

   typedef struct {
      logic                  acc;
      logic [E2eWidth-1:0]   e2e;
      logic [GyrWidth-1:0]   gyr;
      logic [CoordWidth-1:0] mx;
      logic [CoordWidth-1:0] my;
   } chain_result_type;

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [1:0]            req_type;
   logic                  req_chain_end;
   logic [1:0]            req_direction;
   logic [IndexWidth-1:0] req_monomer_index;
   logic [1:0]            req_symmetry_op;
   logic                  rsp_valid;
   logic                  rsp_accepted;
   logic [E2eWidth-1:0]   rsp_end_to_end_sq;
   logic [GyrWidth-1:0]   rsp_gyration_scaled;
   logic [CoordWidth-1:0] rsp_monomer_x;
   logic [CoordWidth-1:0] rsp_monomer_y;

   int pos_x [NMON];
   int pos_y [NMON];
   chain_result_type pending_results[$];
   int mismatch_count;
   int cycle_count;
   bit allow_idle;

   lattice_polymer_move_engine #(.CHAIN_LEN(NMON)) dut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_type(req_type),
      .req_chain_end(req_chain_end),
      .req_direction(req_direction),
      .req_monomer_index(req_monomer_index),
      .req_symmetry_op(req_symmetry_op),
      .rsp_valid(rsp_valid),
      .rsp_accepted(rsp_accepted),
      .rsp_end_to_end_sq(rsp_end_to_end_sq),
      .rsp_gyration_scaled(rsp_gyration_scaled),
      .rsp_monomer_x(rsp_monomer_x),
      .rsp_monomer_y(rsp_monomer_y)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   function automatic void recenter_chain();
      int sx;
      int sy;
      sx = BOX_CTR - pos_x[MID_MON];
      sy = BOX_CTR - pos_y[MID_MON];
      for (int i = 0; i < NMON; i++) begin
         pos_x[i] += sx;
         pos_y[i] += sy;
      end
   endfunction

   function automatic bit try_reptation(logic at_last, dir_code_type dir);
      int head;
      int tail;
      int nx;
      int ny;
      head = at_last ? NMON - 1 : 0;
      tail = at_last ? 0 : NMON - 1;
      nx = pos_x[head];
      ny = pos_y[head];
      case (dir)
         DIR_MINUS_X: nx--;
         DIR_PLUS_X:  nx++;
         DIR_MINUS_Y: ny--;
         default:     ny++;
      endcase
      for (int i = 0; i < NMON; i++)
         if (pos_x[i] == nx && pos_y[i] == ny && i != tail) return 1'b0;
      if (at_last) begin
         for (int i = 0; i < NMON - 1; i++) begin
            pos_x[i] = pos_x[i + 1];
            pos_y[i] = pos_y[i + 1];
         end
      end else begin
         for (int i = NMON - 1; i > 0; i--) begin
            pos_x[i] = pos_x[i - 1];
            pos_y[i] = pos_y[i - 1];
         end
      end
      pos_x[head] = nx;
      pos_y[head] = ny;
      return 1'b1;
   endfunction

   function automatic bit try_pivot(int p, sym_code_type op);
      int px;
      int py;
      int dx;
      int dy;
      int nx [NMON];
      int ny [NMON];
      if (p >= NMON) return 1'b0;
      px = pos_x[p];
      py = pos_y[p];
      for (int i = p; i < NMON; i++) begin
         dx = pos_x[i] - px;
         dy = pos_y[i] - py;
         case (op)
            SYM_ROT_CCW:  begin nx[i] = px - dy; ny[i] = py + dx; end
            SYM_ROT_CW:   begin nx[i] = px + dy; ny[i] = py - dx; end
            SYM_MIRROR_Y: begin nx[i] = px + dx; ny[i] = py - dy; end
            default:      begin nx[i] = px - dx; ny[i] = py + dy; end
         endcase
         for (int j = 0; j < p; j++)
            if (nx[i] == pos_x[j] && ny[i] == pos_y[j]) return 1'b0;
      end
      for (int i = p; i < NMON; i++) begin
         pos_x[i] = nx[i];
         pos_y[i] = ny[i];
      end
      return 1'b1;
   endfunction

   function automatic chain_result_type apply_chain_request(req_code_type rt, logic at_last,
         dir_code_type dir, int idx, sym_code_type op);
      chain_result_type r;
      longint sx;
      longint sy;
      longint sq;
      longint x;
      longint y;
      r.acc = 1'b0;
      r.mx = '0;
      r.my = '0;
      case (rt)
         REQ_REPTATE: r.acc = try_reptation(at_last, dir);
         REQ_PIVOT:   r.acc = try_pivot(idx, op);
         REQ_READ: begin
            if (idx < NMON) begin
               r.mx = CoordWidth'(pos_x[idx]);
               r.my = CoordWidth'(pos_y[idx]);
            end
         end
         default: ;
      endcase
      if (r.acc) recenter_chain();
      x = pos_x[0] - pos_x[NMON - 1];
      y = pos_y[0] - pos_y[NMON - 1];
      r.e2e = E2eWidth'(x * x + y * y);
      sx = 0;
      sy = 0;
      sq = 0;
      for (int i = 0; i < NMON; i++) begin
         x = pos_x[i] - BOX_CTR;
         y = pos_y[i] - BOX_CTR;
         sx += x;
         sy += y;
         sq += x * x + y * y;
      end
      r.gyr = GyrWidth'(NMON * sq - sx * sx - sy * sy);
      return r;
   endfunction

   task automatic send_request(req_code_type rt, logic at_last, dir_code_type dir,
         logic [IndexWidth-1:0] idx, sym_code_type op);
      start <= 1'b1;
      req_type <= rt;
      req_chain_end <= at_last;
      req_direction <= dir;
      req_monomer_index <= idx;
      req_symmetry_op <= op;
      do @(posedge clock); while (busy);
      pending_results.insert(pending_results.size(),
                             apply_chain_request(rt, at_last, dir, int'(idx), op));
   endtask

   task automatic idle_burst();
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      start <= 1'b0;
      do @(posedge clock); while (pending_results.size() != 0);
   endtask

   task automatic send_random(int kind);
      req_code_type rt;
      rt = req_code_type'(kind);
      send_request(rt, 1'($urandom), dir_code_type'($urandom_range(0, 3)),
                   IndexWidth'($urandom_range(0, NMON - 1)),
                   sym_code_type'($urandom_range(0, 3)));
      idle_burst();
   endtask

   always @(posedge clock) begin
      chain_result_type e;
      if (!reset && rsp_valid) begin
         if (pending_results.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= 10) $display("Unexpected result at cycle %0d", cycle_count);
         end else begin
            e = pending_results.pop_front();
            if (rsp_accepted !== e.acc || rsp_end_to_end_sq !== e.e2e ||
                rsp_gyration_scaled !== e.gyr || rsp_monomer_x !== e.mx ||
                rsp_monomer_y !== e.my) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("Mismatch: exp %0d/%0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d/%0d",
                     e.acc, e.e2e, e.gyr, e.mx, e.my, rsp_accepted, rsp_end_to_end_sq,
                     rsp_gyration_scaled, rsp_monomer_x, rsp_monomer_y);
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   task automatic test_reads();
      send_request(REQ_READ, 1'b0, DIR_MINUS_X, '0, SYM_ROT_CCW);
      send_request(REQ_READ, 1'b1, DIR_PLUS_Y, '1, SYM_MIRROR_X);
      send_request(REQ_READ, 1'b0, DIR_MINUS_X, IndexWidth'(MID_MON), SYM_ROT_CCW);
   endtask

   task automatic test_reptation();
      // Each end stepping onto its neighbor is rejected; then both ends try every direction.
      send_request(REQ_REPTATE, 1'b0, DIR_PLUS_X, '0, SYM_ROT_CCW);
      send_request(REQ_REPTATE, 1'b1, DIR_MINUS_X, '0, SYM_ROT_CCW);
      for (int d = 0; d < 4; d++) begin
         send_request(REQ_REPTATE, 1'b0, dir_code_type'(d), '0, SYM_ROT_CCW);
         send_request(REQ_REPTATE, 1'b1, dir_code_type'(d), '1, SYM_ROT_CW);
      end
   endtask

   task automatic test_pivot();
      send_request(REQ_PIVOT, 1'b0, DIR_MINUS_X, IndexWidth'(NMON - 1), SYM_ROT_CCW);
      send_request(REQ_PIVOT, 1'b0, DIR_MINUS_X, '0, SYM_MIRROR_X);
      for (int s = 0; s < 4; s++)
         send_request(REQ_PIVOT, 1'b1, DIR_PLUS_Y, IndexWidth'(20 + 7 * s), sym_code_type'(s));
      send_request(REQ_PIVOT, 1'b0, DIR_MINUS_X, IndexWidth'(NMON - 2), SYM_ROT_CW);
   endtask

   task automatic test_reserved();
      send_request(REQ_RSVD, 1'b1, DIR_PLUS_Y, '1, SYM_MIRROR_X);
      send_request(REQ_RSVD, 1'b0, DIR_MINUS_X, '0, SYM_ROT_CCW);
      send_request(REQ_READ, 1'b0, DIR_MINUS_X, '1, SYM_ROT_CCW);
   endtask

   task automatic test_random(int count);
      int pick;
      for (int n = 0; n < count; n++) begin
         allow_idle = (n < count - 200);
         if (n == count / 2) drain_results();
         pick = $urandom_range(0, 99);
         if (pick < 40) send_random(int'(REQ_REPTATE));
         else if (pick < 75) send_random(int'(REQ_PIVOT));
         else if (pick < 95) send_random(int'(REQ_READ));
         else send_random(int'(REQ_RSVD));
      end
   endtask

   initial begin
      for (int i = 0; i < NMON; i++) begin
         pos_x[i] = i - MID_MON + BOX_CTR;
         pos_y[i] = BOX_CTR;
      end
      mismatch_count = 0;
      cycle_count = 0;
      allow_idle = 1'b1;
      reset = 1'b1;
      start = 1'b0;
      req_type = REQ_READ;
      req_chain_end = 1'b0;
      req_direction = DIR_MINUS_X;
      req_monomer_index = '0;
      req_symmetry_op = SYM_ROT_CCW;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_reads();
      test_reptation();
      test_pivot();
      test_reserved();
      test_random(1800);
      drain_results();
      repeat (MOVE_CYCLES + 20) @(posedge clock);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

### files.f
rtl/core/lpme_pkg.sv
rtl/core/lpme_cell.sv
rtl/core/lattice_polymer_move_engine.sv
tb/sv/tb.sv
